>>> hw/rtl/clsa_pkg.sv
// Shared constants and codes for the complex log-phase block.
package clsa_pkg;

  localparam int MAX_BITS_DEF   = 128;
  localparam int FRAC_WIDTH_DEF = 46;
  localparam int N_WIDTH        = 64;
  localparam int N_LOG          = 6;
  localparam int PREC_WIDTH     = 8;
  localparam logic [PREC_WIDTH-1:0] PREC_RESET = 8'd128;

  typedef enum logic [1:0] {
    ACT_COMPUTE     = 2'd0,
    ACT_LOAD_FACTOR = 2'd1,
    ACT_LOAD_POWER  = 2'd2,
    ACT_NONE        = 2'd3
  } action_t;

endpackage

>>> hw/rtl/clsa_if.sv
// Channel interfaces: item, result and configuration write.
interface clsa_item_if #(
  parameter int VAL_WIDTH = clsa_pkg::FRAC_WIDTH_DEF + 2
);
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic [clsa_pkg::N_WIDTH-1:0]         n_value;
  logic [7:0]                           entry_index;
  logic signed [VAL_WIDTH-1:0]          entry_re;
  logic signed [VAL_WIDTH-1:0]          entry_im;
  modport source (output valid, action, n_value, entry_index, entry_re, entry_im,
                  input ready);
  modport sink   (input valid, action, n_value, entry_index, entry_re, entry_im,
                  output ready);
endinterface

interface clsa_result_if #(
  parameter int VAL_WIDTH = clsa_pkg::FRAC_WIDTH_DEF + 2
);
  logic                        valid;
  logic                        ready;
  logic signed [VAL_WIDTH-1:0] phase_re;
  logic signed [VAL_WIDTH-1:0] phase_im;
  logic                        too_big;
  modport source (output valid, phase_re, phase_im, too_big, input ready);
  modport sink   (input valid, phase_re, phase_im, too_big, output ready);
endinterface

interface clsa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [clsa_pkg::PREC_WIDTH-1:0]     precision_bits;
  modport source (output valid, precision_bits, input ready);
  modport sink   (input valid, precision_bits, output ready);
endinterface

>>> hw/rtl/clsa_cmul.sv
// Iterative complex multiplier with one shared partial-product multiplier.
module clsa_cmul #(
  parameter int VAL_WIDTH  = clsa_pkg::FRAC_WIDTH_DEF + 2,
  parameter int FRAC_WIDTH = clsa_pkg::FRAC_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [VAL_WIDTH-1:0] ar,
  input  logic signed [VAL_WIDTH-1:0] ai,
  input  logic signed [VAL_WIDTH-1:0] br,
  input  logic signed [VAL_WIDTH-1:0] bi,
  output logic                        done,
  output logic signed [VAL_WIDTH-1:0] yr,
  output logic signed [VAL_WIDTH-1:0] yi
);

  localparam int LO = VAL_WIDTH / 2;
  localparam int HI = VAL_WIDTH - LO;
  localparam int OW = HI + 1;
  localparam int PW = VAL_WIDTH + OW;
  localparam int AW = 2 * VAL_WIDTH + 2;
  localparam logic [3:0] LAST_MUL = 4'd7;
  localparam logic [3:0] ROUND    = 4'd9;

  logic                        busy;
  logic [3:0]                  step;
  logic [2:0]                  tag;
  logic signed [VAL_WIDTH-1:0] a_r, a_i, b_r, b_i;
  logic signed [VAL_WIDTH-1:0] op_a, op_b;
  logic signed [OW-1:0]        op_bh;
  logic signed [PW-1:0]        prod, prod_next;
  logic signed [AW-1:0]        ext, term;
  logic signed [AW-1:0]        acc_re, acc_im;
  logic signed [VAL_WIDTH-1:0] sat_re, sat_im;

  function automatic logic signed [VAL_WIDTH-1:0] round_sat(input logic signed [AW-1:0] s);
    logic signed [AW-1:0] r;
    logic signed [AW-1:0] q;
    r = s + (AW'(1) <<< (FRAC_WIDTH - 1));
    q = r >>> FRAC_WIDTH;
    if (q[AW-1] && !(&q[AW-1:VAL_WIDTH-1])) begin
      round_sat = {1'b1, {(VAL_WIDTH-1){1'b0}}};
    end else if (!q[AW-1] && (|q[AW-1:VAL_WIDTH-1])) begin
      round_sat = {1'b0, {(VAL_WIDTH-1){1'b1}}};
    end else begin
      round_sat = q[VAL_WIDTH-1:0];
    end
  endfunction

  always_comb begin
    op_a  = (step[2:1] == 2'd0 || step[2:1] == 2'd2) ? a_r : a_i;
    op_b  = (step[2:1] == 2'd0 || step[2:1] == 2'd3) ? b_r : b_i;
    op_bh = step[0] ? {op_b[VAL_WIDTH-1], op_b[VAL_WIDTH-1:LO]}
                    : {{(OW-LO){1'b0}}, op_b[LO-1:0]};
    prod_next = op_a * op_bh;
    ext  = AW'(prod);
    term = tag[0] ? (ext <<< LO) : ext;
    sat_re = round_sat(acc_re);
    sat_im = round_sat(acc_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == ROUND);
      if (!busy) begin
        if (start) begin
          a_r    <= ar;
          a_i    <= ai;
          b_r    <= br;
          b_i    <= bi;
          acc_re <= '0;
          acc_im <= '0;
          step   <= '0;
          busy   <= 1'b1;
        end
      end else begin
        step <= step + 4'd1;
        if (step <= LAST_MUL) begin
          prod <= prod_next;
          tag  <= step[2:0];
        end
        if (step != 4'd0 && step <= LAST_MUL + 4'd1) begin
          case (tag[2:1])
            2'd0:    acc_re <= acc_re + term;
            2'd1:    acc_re <= acc_re - term;
            default: acc_im <= acc_im + term;
          endcase
        end
        if (step == ROUND) begin
          yr   <= sat_re;
          yi   <= sat_im;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> hw/rtl/complex_phase_of_log_shift_add.sv
// Top level: shift-and-add log factoring into a complex phase product.
//
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------
//  item     | in  | action, n_value, entry_index, entry_re, entry_im
//  result   | out | phase_re, phase_im, too_big
//  cfg      | in  | precision_bits
//
// A load item with an index up to MAX_BITS writes its table entry. A compute
// item first finds and places the leading bit, then per bit position k runs
// scan/subtract steps and, for each applied factor, a product on the shared
// complex multiplier, plus one final multiply by the power entry. The
// multiplier, one 48x25 product per cycle, sets the length of a compute.
// Reset clears control and sets precision_bits to 128; the tables hold
// garbage until loaded. A stalled result holds; item ready stays low until the
// result has been placed in the output register.
module complex_phase_of_log_shift_add #(
  parameter int MAX_BITS   = clsa_pkg::MAX_BITS_DEF,
  parameter int FRAC_WIDTH = clsa_pkg::FRAC_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  clsa_item_if.sink    item,
  clsa_result_if.source result,
  clsa_cfg_if.sink     cfg
);

  localparam int VW    = FRAC_WIDTH + 2;
  localparam int DEPTH = MAX_BITS + 1;
  localparam int KW    = $clog2(MAX_BITS + 1);
  localparam int XIW   = $clog2(MAX_BITS);
  localparam int CW    = (KW > 7) ? KW + 1 : 8;
  localparam int NW    = clsa_pkg::N_WIDTH;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_NORM   = 10'b0000000010,
    S_PLACE  = 10'b0000000100,
    S_SCAN   = 10'b0000001000,
    S_SUB    = 10'b0000010000,
    S_SUB2   = 10'b0000100000,
    S_RD     = 10'b0001000000,
    S_MSTART = 10'b0010000000,
    S_MWAIT  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t                         state;
  logic [clsa_pkg::PREC_WIDTH-1:0] prec;
  logic [KW-1:0]                  nw, k, raddr;
  logic [NW-1:0]                  n_reg, v;
  logic [clsa_pkg::N_LOG-1:0]     msb, shamt;
  logic [2:0]                     j;
  logic [MAX_BITS-1:0]            x, z, diff;
  logic [MAX_BITS+NW-1:0]         placed;
  logic                           is_pow, tb;
  logic signed [VW-1:0]           yr, yi, br, bi, mr, mi;
  logic                           mdone;
  logic [2*VW-1:0]                fmem [DEPTH];
  logic [2*VW-1:0]                pmem [DEPTH];
  logic [2*VW-1:0]                fdata, pdata;
  logic [KW-1:0]                  n_eff, waddr, pidx;
  logic                           idx_ok, take, kp1_end;
  logic [KW:0]                    kp1;
  logic [XIW-1:0]                 bitpos, nm1;
  logic [CW-1:0]                  a_len, shift;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign take       = item.valid && item.ready;

  always_comb begin
    if (item.action == clsa_pkg::ACT_COMPUTE && prec < 8'd2) begin
      n_eff = KW'(2);
    end else if (32'(prec) > MAX_BITS) begin
      n_eff = KW'(MAX_BITS);
    end else begin
      n_eff = KW'(prec);
    end
    idx_ok  = 32'(item.entry_index) <= MAX_BITS;
    waddr   = KW'(item.entry_index);
    pidx    = KW'(msb);
    shamt   = 6'd1 << j;
    kp1     = (KW+1)'(k) + 1'b1;
    kp1_end = kp1 >= (KW+1)'(nw);
    bitpos  = XIW'(nw - 1'b1 - k);
    nm1     = XIW'(nw - 1'b1);
    z       = x >> k;
    diff    = x - z;
    a_len   = CW'(msb) + 1'b1;
    shift   = CW'(nw) - a_len;
    placed  = (MAX_BITS+NW)'(n_reg) << shift;
    br      = is_pow ? pdata[2*VW-1:VW] : fdata[2*VW-1:VW];
    bi      = is_pow ? pdata[VW-1:0]    : fdata[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (take && idx_ok && item.action == clsa_pkg::ACT_LOAD_FACTOR) begin
      fmem[waddr] <= {item.entry_re, item.entry_im};
    end
    if (take && idx_ok && item.action == clsa_pkg::ACT_LOAD_POWER) begin
      pmem[waddr] <= {item.entry_re, item.entry_im};
    end
    fdata <= fmem[raddr];
    pdata <= pmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prec <= clsa_pkg::PREC_RESET;
    end else if (cfg.valid && cfg.ready) begin
      prec <= cfg.precision_bits;
    end
  end

  clsa_cmul #(.VAL_WIDTH(VW), .FRAC_WIDTH(FRAC_WIDTH)) u_cmul (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_MSTART),
    .ar    (yr),
    .ai    (yi),
    .br    (br),
    .bi    (bi),
    .done  (mdone),
    .yr    (mr),
    .yi    (mi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_DONE) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take && item.action == clsa_pkg::ACT_COMPUTE) begin
            n_reg <= item.n_value;
            v     <= item.n_value;
            msb   <= '0;
            j     <= 3'd5;
            nw    <= n_eff;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if ((v >> shamt) != '0) begin
            v   <= v >> shamt;
            msb <= msb | shamt;
          end
          j <= j - 3'd1;
          if (j == 3'd0) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (a_len > CW'(nw)) begin
            yr    <= '0;
            yi    <= '0;
            tb    <= 1'b1;
            state <= S_DONE;
          end else begin
            x     <= placed[MAX_BITS-1:0];
            k     <= KW'(1);
            yr    <= VW'(1) <<< FRAC_WIDTH;
            yi    <= '0;
            tb    <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (x[bitpos]) begin
            state <= S_SUB;
          end else begin
            k <= KW'(kp1);
            if (kp1_end) begin
              raddr  <= pidx;
              is_pow <= 1'b1;
              state  <= S_RD;
            end
          end
        end
        S_SUB: begin
          k <= KW'(kp1);
          if (diff[nm1]) begin
            x      <= diff;
            raddr  <= k;
            is_pow <= 1'b0;
            state  <= S_RD;
          end else if (kp1_end) begin
            raddr  <= pidx;
            is_pow <= 1'b1;
            state  <= S_RD;
          end else begin
            state <= S_SUB2;
          end
        end
        S_SUB2: begin
          x      <= diff;
          raddr  <= k;
          is_pow <= 1'b0;
          state  <= S_RD;
        end
        S_RD: begin
          state <= S_MSTART;
        end
        S_MSTART: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mdone) begin
            yr <= mr;
            yi <= mi;
            if (is_pow) begin
              state <= S_DONE;
            end else if (k >= nw) begin
              raddr  <= pidx;
              is_pow <= 1'b1;
              state  <= S_RD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid    <= 1'b1;
            result.phase_re <= yr;
            result.phase_im <= yi;
            result.too_big  <= tb;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/clsa_check.sv
// Port-level checker for the complex log-phase block, with its bind.
module clsa_check #(
  parameter int VW = clsa_pkg::FRAC_WIDTH_DEF + 2
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic [1:0]    in_action,
  input logic          out_valid,
  input logic          out_ready,
  input logic [VW-1:0] out_re,
  input logic [VW-1:0] out_im,
  input logic          out_tb
);

  a_tb_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_tb |-> out_re == '0 && out_im == '0)
    else $error("too_big result with nonzero phase");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_action == clsa_pkg::ACT_COMPUTE |=> !in_ready)
    else $error("item taken while a compute is in progress");

  a_no_out_on_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_action != clsa_pkg::ACT_COMPUTE && !out_valid
    |=> !out_valid)
    else $error("result produced by a non-compute item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im)
    && $stable(out_tb))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind complex_phase_of_log_shift_add clsa_check #(.VW(FRAC_WIDTH + 2)) u_clsa_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_action (item.action),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_re    (result.phase_re),
  .out_im    (result.phase_im),
  .out_tb    (result.too_big)
);

>>> test/clsa_checker.sv
// Watches the item, config and result channels, predicts each phase and compares.
module clsa_checker
  import clsa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  clsa_item_if   item,
  clsa_result_if result,
  clsa_cfg_if    cfg,
  output int     failures,
  output int     pending,
  output int     computes,
  output int     too_big_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = FRAC_WIDTH_DEF + 2;

  typedef struct packed {
    logic signed [VW-1:0] re;
    logic signed [VW-1:0] im;
    logic                 big;
  } phase_t;

  logic signed [VW-1:0] fac_re [0:MAX_BITS_DEF];
  logic signed [VW-1:0] fac_im [0:MAX_BITS_DEF];
  logic signed [VW-1:0] pow_re [0:MAX_BITS_DEF];
  logic signed [VW-1:0] pow_im [0:MAX_BITS_DEF];
  logic [PREC_WIDTH-1:0] prec;
  phase_t phase_q[$];

  function automatic logic signed [VW-1:0] round_sat(input logic signed [2*VW+1:0] s);
    logic signed [2*VW+1:0] t;
    t = (s + (98'sd1 <<< (FRAC_WIDTH_DEF - 1))) >>> FRAC_WIDTH_DEF;
    if (t[2*VW+1:VW-1] != {(VW+3){t[2*VW+1]}})
      return t[2*VW+1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    return t[VW-1:0];
  endfunction

  function automatic void cmul(inout logic signed [VW-1:0] yr, yi,
                               input logic signed [VW-1:0] br, bi);
    logic signed [2*VW+1:0] pr, pi;
    pr = yr * br - yi * bi;
    pi = yr * bi + yi * br;
    yr = round_sat(pr);
    yi = round_sat(pi);
  endfunction

  function automatic phase_t log_phase(input logic [N_WIDTH-1:0] n);
    phase_t r;
    int nw, a, k;
    logic [MAX_BITS_DEF-1:0] x, z;
    logic signed [VW-1:0] yr, yi;
    nw = (prec < 2) ? 2 : (prec > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(prec);
    a = 0;
    while (a < 64 && (n >> a) != 0) a++;
    if (a == 0) a = 1;
    r = '0;
    if (a > nw) begin
      r.big = 1'b1;
      return r;
    end
    x = MAX_BITS_DEF'(n) << (nw - a);
    yr = 48'sd1 <<< FRAC_WIDTH_DEF;
    yi = '0;
    k = 1;
    while (k < nw) begin
      while (k < nw && !x[nw-1-k]) k++;
      if (k >= nw) break;
      z = x >> k;
      x = x - z;
      if (x[nw-1]) begin
        cmul(yr, yi, fac_re[k], fac_im[k]);
        k++;
      end else begin
        x = x + z;
        z = z >> 1;
        k++;
        if (k >= nw) break;
        x = x - z;
        cmul(yr, yi, fac_re[k], fac_im[k]);
      end
    end
    cmul(yr, yi, pow_re[a-1], pow_im[a-1]);
    r.re = yr;
    r.im = yi;
    return r;
  endfunction

  always @(posedge clk) begin
    phase_t exp_p;
    if (rst) begin
      prec <= PREC_RESET;
      failures <= 0;
      computes <= 0;
      too_big_seen <= 0;
      pending <= 0;
      phase_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) prec <= cfg.precision_bits;
      if (item.valid && item.ready) begin
        case (action_t'(item.action))
          ACT_COMPUTE: begin
            exp_p = log_phase(item.n_value);
            phase_q.push_back(exp_p);
            computes <= computes + 1;
            if (exp_p.big) too_big_seen <= too_big_seen + 1;
          end
          ACT_LOAD_FACTOR: if (item.entry_index <= MAX_BITS_DEF) begin
            fac_re[item.entry_index] = item.entry_re;
            fac_im[item.entry_index] = item.entry_im;
          end
          ACT_LOAD_POWER: if (item.entry_index <= MAX_BITS_DEF) begin
            pow_re[item.entry_index] = item.entry_re;
            pow_im[item.entry_index] = item.entry_im;
          end
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (phase_q.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h too_big=%b", $time,
                   result.phase_re, result.phase_im, result.too_big);
          failures <= failures + 1;
        end else begin
          exp_p = phase_q.pop_front();
          if (exp_p.re !== result.phase_re || exp_p.im !== result.phase_im ||
              exp_p.big !== result.too_big) begin
            $display("%0t: mismatch expected re=%h im=%h too_big=%b actual re=%h im=%h too_big=%b",
                     $time, exp_p.re, exp_p.im, exp_p.big,
                     result.phase_re, result.phase_im, result.too_big);
            failures <= failures + 1;
          end
        end
      end
      pending <= phase_q.size();
    end
  end
endmodule

>>> test/tb_top.sv
// Testbench top: clock, reset, stimulus with bursty sender and stalling receiver, verdict.
module tb_top;
  import clsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = FRAC_WIDTH_DEF + 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int failures, pending, computes, too_big_seen;
  int burst_left = 0;
  int sent = 0;
  int stall_cnt = 0;

  clsa_item_if   item ();
  clsa_result_if result ();
  clsa_cfg_if    cfg ();

  complex_phase_of_log_shift_add DUT (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg)
  );

  clsa_checker u_checker (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg),
    .failures(failures), .pending(pending), .computes(computes),
    .too_big_seen(too_big_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case (stall_cnt[11:10])
      2'd0: result.ready <= 1'b1;
      2'd1: result.ready <= ($urandom_range(3) != 0);
      2'd2: result.ready <= ((stall_cnt % 7) < 3);
      default: result.ready <= 1'($urandom_range(1));
    endcase
  end

  function automatic logic signed [VW-1:0] entry_val();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(7) == 0) return r[VW-1:0];
    return VW'($signed(r[FRAC_WIDTH_DEF:0]));
  endfunction

  function automatic logic [N_WIDTH-1:0] pick_n(input int nw);
    logic [63:0] r;
    int a;
    r = {$urandom, $urandom};
    if ($urandom_range(9) == 0) return r;
    a = $urandom_range(1, (nw + 2 > 64) ? 64 : nw + 2);
    r = r >> (64 - a);
    r[a-1] = 1'b1;
    return r;
  endfunction

  task automatic send(input action_t act, input logic [N_WIDTH-1:0] n,
                      input logic [7:0] idx, input logic signed [VW-1:0] re,
                      input logic signed [VW-1:0] im);
    item.valid       <= 1'b1;
    item.action      <= act;
    item.n_value     <= n;
    item.entry_index <= idx;
    item.entry_re    <= re;
    item.entry_im    <= im;
    @(negedge clk);
    while (!item.ready) @(negedge clk);
    @(posedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 16);
    end
  endtask

  task automatic settle();
    item.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_prec(input logic [PREC_WIDTH-1:0] p);
    cfg.valid          <= 1'b1;
    cfg.precision_bits <= p;
    @(negedge clk);
    while (!cfg.ready) @(negedge clk);
    @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_phase(input int cnt, input int nw);
    int sel;
    for (int i = 0; i < cnt; i++) begin
      sel = $urandom_range(19);
      if (sel < 13)
        send(ACT_COMPUTE, pick_n(nw), 8'($urandom), entry_val(), entry_val());
      else if (sel < 15)
        send(ACT_LOAD_FACTOR, {$urandom, $urandom}, 8'($urandom_range(MAX_BITS_DEF)),
             entry_val(), entry_val());
      else if (sel < 17)
        send(ACT_LOAD_POWER, {$urandom, $urandom}, 8'($urandom_range(MAX_BITS_DEF)),
             entry_val(), entry_val());
      else if (sel < 18)
        send(action_t'($urandom_range(1, 2)), '0,
             8'($urandom_range(MAX_BITS_DEF + 1, 255)), entry_val(), entry_val());
      else
        send(ACT_NONE, {$urandom, $urandom}, 8'($urandom), entry_val(), entry_val());
    end
  endtask

  initial begin
    logic [PREC_WIDTH-1:0] precs [8] = '{8'd2, 8'd0, 8'd1, 8'd255, 8'd64, 8'd129, 8'd20, 8'd7};
    int nw;
    item.valid = 1'b0;
    item.action = ACT_NONE;
    item.n_value = '0;
    item.entry_index = '0;
    item.entry_re = '0;
    item.entry_im = '0;
    cfg.valid = 1'b0;
    cfg.precision_bits = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i <= MAX_BITS_DEF; i++) begin
      send(ACT_LOAD_FACTOR, '0, 8'(i), entry_val(), entry_val());
      send(ACT_LOAD_POWER, '0, 8'(i), entry_val(), entry_val());
    end
    settle();
    write_prec(8'd128);

    send(ACT_LOAD_POWER, '0, 8'd0, {1'b0, {(VW-1){1'b1}}}, {1'b1, {(VW-1){1'b0}}});
    send(ACT_COMPUTE, 64'd0, '0, '0, '0);
    send(ACT_COMPUTE, 64'd1, '0, '0, '0);
    send(ACT_LOAD_POWER, '0, 8'd0, {1'b1, {(VW-1){1'b0}}}, {1'b0, {(VW-1){1'b1}}});
    send(ACT_COMPUTE, 64'd0, '0, '0, '0);
    send(ACT_LOAD_FACTOR, '0, 8'd128, entry_val(), entry_val());
    send(ACT_LOAD_FACTOR, '0, 8'd129, '0, '0);
    send(ACT_LOAD_POWER, '0, 8'd255, '0, '0);
    send(ACT_NONE, 64'd5, '0, '0, '0);
    send(ACT_COMPUTE, 64'd2, '0, '0, '0);
    send(ACT_COMPUTE, 64'd3, '0, '0, '0);
    send(ACT_COMPUTE, '1, '0, '0, '0);
    send(ACT_COMPUTE, 64'h8000_0000_0000_0000, '0, '0, '0);
    send(ACT_COMPUTE, 64'h5555_5555_5555_5555, '0, '0, '0);
    send(ACT_COMPUTE, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0, '0);
    random_phase(20, 128);
    settle();

    foreach (precs[p]) begin
      write_prec(precs[p]);
      nw = (precs[p] < 2) ? 2 : (precs[p] > 128) ? 128 : precs[p];
      if (nw == 2) begin
        send(ACT_COMPUTE, 64'd3, '0, '0, '0);
        send(ACT_COMPUTE, 64'd4, '0, '0, '0);
      end
      random_phase(10, nw);
      settle();
    end
    write_prec(PREC_RESET);
    random_phase(20, 128);
    settle();

    $display("Sent %0d items over 10 precision settings (2..255 incl. clamped values).", sent);
    $display("Checked %0d phase results, %0d of them flagged too big.", computes, too_big_seen);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end
endmodule
